/* rtl/ple_pkg.sv */
package ple_pkg;

  // List geometry.
  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Port field widths.
  localparam int ACTION_W = 2;
  localparam int POS_W    = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 6;
  localparam int COUNT_W  = 7;

  // Width used to compare a requested position against the entry count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT     = 2'd0,
    ACT_REMOVE_POS = 2'd1,
    ACT_REMOVE_VAL = 2'd2,
    ACT_FIND       = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_FRONT,
    S_RESP
  } ctrl_state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PREV,
    RD_NEXT,
    RD_IDX,
    RD_FRONT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_VALUE
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    idx_op_e idx_op;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_full;
    logic    set_miss;
    logic    set_found;
    logic    done;
  } ple_cmd_t;

  typedef struct packed {
    action_e action;
    logic    full;
    logic    pos_miss;
    logic    ins_more;
    logic    del_more;
    logic    srch_more;
    logic    match;
  } ple_stat_t;

endpackage

/* rtl/ple_ram.sv */
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/ple_ctrl.sv */
module ple_ctrl
  import ple_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  ple_stat_t stat_i,
  output ple_cmd_t  cmd_o,
  output logic      busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, idx_op: IDX_HOLD, rd_sel: RD_NONE, wr_sel: WR_NONE,
                cnt_inc: 1'b0, cnt_dec: 1'b0, set_full: 1'b0, set_miss: 1'b0,
                set_found: 1'b0, done: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.action)
          ACT_INSERT: begin
            if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
              state_d        = S_FRONT;
            end else begin
              cmd_o.idx_op = IDX_COUNT;
              state_d      = S_INS_CHK;
            end
          end
          ACT_REMOVE_POS: begin
            if (stat_i.pos_miss) begin
              cmd_o.set_miss = 1'b1;
              state_d        = S_FRONT;
            end else begin
              cmd_o.idx_op = IDX_POS;
              state_d      = S_DEL_CHK;
            end
          end
          ACT_REMOVE_VAL, ACT_FIND: begin
            cmd_o.idx_op = IDX_ZERO;
            state_d      = S_SRCH_CHK;
          end
          default: state_d = S_FRONT;
        endcase
      end
      // Entries from the insert position on move back by one, last first.
      S_INS_CHK: begin
        if (stat_i.ins_more) begin
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_INS_WR;
        end else begin
          cmd_o.wr_sel  = WR_VALUE;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_FRONT;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_INS_CHK;
      end
      // Entries after the removed one move forward by one, first first.
      S_DEL_CHK: begin
        if (stat_i.del_more) begin
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_DEL_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FRONT;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_DEL_CHK;
      end
      S_SRCH_CHK: begin
        if (stat_i.srch_more) begin
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_SRCH_CMP;
        end else begin
          cmd_o.set_miss = 1'b1;
          state_d        = S_FRONT;
        end
      end
      S_SRCH_CMP: begin
        if (stat_i.match) begin
          cmd_o.set_found = 1'b1;
          state_d = (stat_i.action == ACT_REMOVE_VAL) ? S_DEL_CHK : S_FRONT;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_SRCH_CHK;
        end
      end
      S_FRONT: begin
        cmd_o.rd_sel = RD_FRONT;
        state_d      = S_RESP;
      end
      S_RESP: begin
        cmd_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_DECODE))
    else $error("accepted item did not start decoding");

  a_resp_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.done |=> !busy_o)
    else $error("block still busy after its result");

  a_write_not_with_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_sel != WR_NONE) |-> (cmd_o.rd_sel == RD_NONE))
    else $error("store written and read in the same cycle");
`endif

endmodule

/* rtl/ple_dp.sv */
module ple_dp
  import ple_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ple_cmd_t            cmd_i,
  output ple_stat_t           stat_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [WORD_W-1:0]   value_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                found_o,
  output logic [FIDX_W-1:0]   found_index_o,
  output logic [COUNT_W-1:0]  entry_count_o,
  output logic                is_empty_o,
  output logic [WORD_W-1:0]   front_value_o
);

  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      idx_q;
  logic [CNT_W-1:0]      pos_q;
  logic                  pos_miss_q;
  action_e               action_q;
  logic [VALUE_BITS-1:0] value_q;
  status_e               status_q;
  logic                  found_q;
  logic [ADDR_W-1:0]     found_idx_q;

  logic [CNT_W-1:0]      idx_m1, idx_p1;
  logic [CMP_W-1:0]      pos_ext, cnt_ext;
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

  assign idx_m1  = idx_q - CNT_W'(1);
  assign idx_p1  = idx_q + CNT_W'(1);
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q    <= action_e'(action_i);
      value_q     <= value_i[VALUE_BITS-1:0];
      // An insert past the end appends; a removal uses the flag instead.
      pos_q       <= (pos_ext > cnt_ext) ? count_q : CNT_W'(position_i);
      pos_miss_q  <= (pos_ext >= cnt_ext);
      status_q    <= ST_DONE;
      found_q     <= 1'b0;
      found_idx_q <= '0;
    end else begin
      if (cmd_i.set_full) begin
        status_q <= ST_FULL;
      end
      if (cmd_i.set_miss) begin
        status_q <= ST_MISS;
      end
      if (cmd_i.set_found) begin
        found_q     <= 1'b1;
        found_idx_q <= idx_q[ADDR_W-1:0];
      end
    end
    unique case (cmd_i.idx_op)
      IDX_HOLD:  idx_q <= idx_q;
      IDX_COUNT: idx_q <= count_q;
      IDX_POS:   idx_q <= pos_q;
      IDX_ZERO:  idx_q <= '0;
      IDX_INC:   idx_q <= idx_p1;
      IDX_DEC:   idx_q <= idx_m1;
      default:   idx_q <= idx_q;
    endcase
  end

  always_comb begin
    ram_raddr = '0;
    unique case (cmd_i.rd_sel)
      RD_PREV:  ram_raddr = idx_m1[ADDR_W-1:0];
      RD_NEXT:  ram_raddr = idx_p1[ADDR_W-1:0];
      RD_IDX:   ram_raddr = idx_q[ADDR_W-1:0];
      RD_FRONT: ram_raddr = '0;
      RD_NONE:  ram_raddr = '0;
      default:  ram_raddr = '0;
    endcase
  end

  assign ram_re    = (cmd_i.rd_sel != RD_NONE);
  assign ram_we    = (cmd_i.wr_sel != WR_NONE);
  assign ram_waddr = (cmd_i.wr_sel == WR_VALUE) ? pos_q[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
  assign ram_wdata = (cmd_i.wr_sel == WR_VALUE) ? value_q : ram_rdata;

  ple_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stat_o.action    = action_q;
  assign stat_o.full      = (count_q >= CNT_W'(CAPACITY));
  assign stat_o.pos_miss  = pos_miss_q;
  assign stat_o.ins_more  = (idx_q > pos_q);
  assign stat_o.del_more  = (idx_p1 < count_q);
  assign stat_o.srch_more = (idx_q < count_q);
  assign stat_o.match     = (ram_rdata == value_q);

  // The front entry was read in the cycle before the result.
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign found_index_o = FIDX_W'(found_idx_q);
  assign entry_count_o = COUNT_W'(count_q);
  assign is_empty_o    = (count_q == '0);
  assign front_value_o = (count_q == '0) ? '0 : WORD_W'(ram_rdata);

`ifndef SYNTHESIS
  a_count_steps_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
      || (count_q + CNT_W'(1) == $past(count_q)))
    else $error("entry count moved by more than one");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (count_q < CNT_W'(CAPACITY)))
    else $error("insert completed into a full list");

  a_found_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_found |-> (stat_o.match && (idx_q < count_q)))
    else $error("match recorded without an equal valid entry");
`endif

endmodule

/* rtl/positional_list_engine.sv */
// Ordered list of up to 64 words with insert, remove and search commands.
//
// Command channel: drive action_i, position_i and value_i with start_i high;
// the command transfers at the rising edge where start_i is high and busy_o
// is low. busy_o stays high until the result has been presented.
// Result channel: done_o is high for exactly one cycle, and status_o,
// found_o, found_index_o, entry_count_o, is_empty_o and front_value_o are
// valid in that cycle only. The receiver cannot stall; the result transfers
// at the edge that ends the done_o cycle, and the next command may transfer
// at the edge after it.
// Command time grows with the entries moved or compared, with c the entry
// count before the command: an insert moves the entries from its position on,
// a remove at a position moves the entries behind it, a find compares entries
// up to the hit or all c on a miss, and a remove by value compares likewise
// and on a hit then moves the entries behind it. A full insert or an
// out-of-range removal moves and compares none. Each moved or compared entry
// takes a read and then a write or compare on the single entry store.
// Reset clears the entry count and returns the controller to idle; the
// store contents are not cleared and need no clearing pass.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [WORD_W-1:0]   value_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                found_o,
  output logic [FIDX_W-1:0]   found_index_o,
  output logic [COUNT_W-1:0]  entry_count_o,
  output logic                is_empty_o,
  output logic [WORD_W-1:0]   front_value_o
);

  ple_cmd_t  cmd;
  ple_stat_t stat;

  ple_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  ple_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .found_index_o (found_index_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .front_value_o (front_value_o)
  );

  assign done_o = cmd.done;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ple_pkg::*;

  typedef struct {
    status_e             status;
    logic                found;
    logic [FIDX_W-1:0]   found_idx;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    logic [WORD_W-1:0]   front;
  } list_result_t;

  typedef struct {
    action_e             act;
    logic [POS_W-1:0]    pos;
    logic [WORD_W-1:0]   val;
    bit                  typed;
    list_result_t        res;
  } stim_row_t;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} mix_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [ACTION_W-1:0] action_i;
  logic [POS_W-1:0]    position_i;
  logic [WORD_W-1:0]   value_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic                found_o;
  logic [FIDX_W-1:0]   found_index_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic                is_empty_o;
  logic [WORD_W-1:0]   front_value_o;

  // Shadow copy of the list, kept in step with every accepted command.
  logic [WORD_W-1:0] shadow_entries [CAPACITY];
  int                shadow_count;
  list_result_t      pending_results [$];
  logic [WORD_W-1:0] value_pool [8];
  stim_row_t         dir_rows [$];
  int                fail_cnt = 0;

  always #6 clk_i = ~clk_i;

  positional_list_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .found_index_o (found_index_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .front_value_o (front_value_o)
  );

  function automatic void remove_entry(int p);
    int i;
    for (i = p; i + 1 < shadow_count; i++) begin
      shadow_entries[i] = shadow_entries[i + 1];
    end
    shadow_count--;
  endfunction

  // Applies one command to the shadow list and returns the result it yields.
  function automatic list_result_t list_apply(action_e act, logic [POS_W-1:0] pos,
                                              logic [WORD_W-1:0] val);
    list_result_t r;
    int p;
    int i;
    int hit;
    r.status    = ST_DONE;
    r.found     = 1'b0;
    r.found_idx = '0;
    case (act)
      ACT_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          p = (int'(pos) > shadow_count) ? shadow_count : int'(pos);
          for (i = shadow_count; i > p; i--) begin
            shadow_entries[i] = shadow_entries[i - 1];
          end
          shadow_entries[p] = val;
          shadow_count++;
        end
      end
      ACT_REMOVE_POS: begin
        if (int'(pos) >= shadow_count) begin
          r.status = ST_MISS;
        end else begin
          remove_entry(int'(pos));
        end
      end
      default: begin
        hit = shadow_count;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_entries[i] == val) begin
            hit = i;
            break;
          end
        end
        if (hit >= shadow_count) begin
          r.status = ST_MISS;
        end else begin
          r.found     = 1'b1;
          r.found_idx = FIDX_W'(hit);
          if (act == ACT_REMOVE_VAL) begin
            remove_entry(hit);
          end
        end
      end
    endcase
    r.count = COUNT_W'(shadow_count);
    r.empty = (shadow_count == 0);
    r.front = (shadow_count == 0) ? '0 : shadow_entries[0];
    return r;
  endfunction

  function automatic stim_row_t make_row(action_e a, int p, logic [WORD_W-1:0] v, bit typed,
                                         status_e st, bit fnd, int idx, int cnt,
                                         logic [WORD_W-1:0] front);
    stim_row_t row;
    row.act           = a;
    row.pos           = POS_W'(p);
    row.val           = v;
    row.typed         = typed;
    row.res.status    = st;
    row.res.found     = fnd;
    row.res.found_idx = FIDX_W'(idx);
    row.res.count     = COUNT_W'(cnt);
    row.res.empty     = (cnt == 0);
    row.res.front     = front;
    return row;
  endfunction

  task automatic check_result(input list_result_t e);
    if (status_o !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status_o);
      fail_cnt++;
    end
    if (found_o !== e.found) begin
      $error("found: expected %0d, got %0d", e.found, found_o);
      fail_cnt++;
    end
    if (found_index_o !== e.found_idx) begin
      $error("found_index: expected %0d, got %0d", e.found_idx, found_index_o);
      fail_cnt++;
    end
    if (entry_count_o !== e.count) begin
      $error("entry_count: expected %0d, got %0d", e.count, entry_count_o);
      fail_cnt++;
    end
    if (is_empty_o !== e.empty) begin
      $error("is_empty: expected %0d, got %0d", e.empty, is_empty_o);
      fail_cnt++;
    end
    if (front_value_o !== e.front) begin
      $error("front_value: expected 0x%08h, got 0x%08h", e.front, front_value_o);
      fail_cnt++;
    end
  endtask

  // Sampled at the edge that ends the done_o cycle, which is when the result transfers.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_cnt++;
      end else begin
        check_result(pending_results.pop_front());
      end
    end
  end

  // Presents one command, holds it until it transfers, then records what it should yield.
  task automatic send_item(action_e act, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val,
                           bit typed, list_result_t typed_res, int idle_pct);
    list_result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy_o);
    r = list_apply(act, pos, val);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic pick_item(mix_e mode, output action_e act, output logic [POS_W-1:0] pos,
                           output logic [WORD_W-1:0] val);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   act = (r < 80) ? ACT_INSERT : action_e'($urandom_range(1, 3));
      MODE_SHRINK: begin
        if (r < 40)      act = ACT_REMOVE_POS;
        else if (r < 80) act = ACT_REMOVE_VAL;
        else if (r < 90) act = ACT_FIND;
        else             act = ACT_INSERT;
      end
      default:     act = action_e'($urandom_range(0, 3));
    endcase
    if ($urandom_range(0, 99) < 25) begin
      pos = POS_W'($urandom_range(0, 255));
    end else if (act == ACT_REMOVE_POS && shadow_count > 0) begin
      pos = POS_W'($urandom_range(0, shadow_count - 1));
    end else begin
      pos = POS_W'($urandom_range(0, shadow_count));
    end
    r = $urandom_range(0, 9);
    if (r < 4 && shadow_count > 0) begin
      val = shadow_entries[$urandom_range(0, shadow_count - 1)];
    end else if (r < 6) begin
      val = value_pool[$urandom_range(0, 7)];
    end else begin
      val = $urandom;
    end
  endtask

  // Grow and shrink segments run a few commands past the full and empty list.
  task automatic run_segment(mix_e mode, int idle_pct);
    int n;
    int extra;
    action_e a;
    logic [POS_W-1:0] p;
    logic [WORD_W-1:0] v;
    list_result_t unused;
    n     = 0;
    extra = 0;
    unused = '{status: ST_DONE, found: 1'b0, found_idx: '0, count: '0, empty: 1'b0,
               front: '0};
    while (!((mode == MODE_MIX && n >= 40) || (mode != MODE_MIX && extra > 3))) begin
      if ((mode == MODE_GROW && shadow_count == CAPACITY) ||
          (mode == MODE_SHRINK && shadow_count == 0)) begin
        extra++;
      end
      pick_item(mode, a, p, v);
      send_item(a, p, v, 1'b0, unused, idle_pct);
      n++;
    end
  endtask

  initial begin
    int idle_pcts [3];
    rst_ni     = 1'b0;
    start_i    <= 1'b0;
    action_i   <= '0;
    position_i <= '0;
    value_i    <= '0;
    shadow_count = 0;
    idle_pcts = '{0, 65, 16};
    value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0000_0001, 32'hA5A5_A5A5, $urandom, $urandom};

    // Empty list, front and append ends, duplicates, hits and misses on both removals.
    dir_rows.push_back(make_row(ACT_FIND, 0, 32'h0, 1, ST_MISS, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_POS, 0, 32'h0, 1, ST_MISS, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_VAL, 0, 32'hFFFF_FFFF, 1, ST_MISS, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_POS, 255, 32'h0, 1, ST_MISS, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_INSERT, 255, 32'hFFFF_FFFF, 1, ST_DONE, 0, 0, 1,
                                32'hFFFF_FFFF));
    dir_rows.push_back(make_row(ACT_FIND, 0, 32'hFFFF_FFFF, 1, ST_DONE, 1, 0, 1,
                                32'hFFFF_FFFF));
    dir_rows.push_back(make_row(ACT_INSERT, 0, 32'h0, 1, ST_DONE, 0, 0, 2, 32'h0));
    dir_rows.push_back(make_row(ACT_INSERT, 1, 32'h1234_5678, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_INSERT, 2, 32'h0, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_INSERT, 3, 32'h1, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_INSERT, 5, 32'h8000_0000, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_INSERT, 200, 32'h7FFF_FFFF, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_FIND, 77, 32'h0, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_FIND, 0, 32'h7FFF_FFFF, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_FIND, 0, 32'h55AA_55AA, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_VAL, 0, 32'h0, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_VAL, 0, 32'h0, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_VAL, 0, 32'h0, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_POS, 5, 32'h0, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_POS, 4, 32'h0, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_POS, 0, 32'h0, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_REMOVE_POS, 128, 32'h0, 0, ST_DONE, 0, 0, 0, 32'h0));
    dir_rows.push_back(make_row(ACT_FIND, 170, 32'hAAAA_AAAA, 0, ST_DONE, 0, 0, 0, 32'h0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].act, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].typed,
                dir_rows[i].res, 0);
    end
    wait_drained();

    // The list is filled and emptied once; later phases run mixed traffic only.
    foreach (idle_pcts[k]) begin
      if (k == 0) run_segment(MODE_GROW, idle_pcts[k]);
      run_segment(MODE_MIX, idle_pcts[k]);
      if (k == 0) run_segment(MODE_SHRINK, idle_pcts[k]);
      run_segment(MODE_MIX, idle_pcts[k]);
      wait_drained();
    end

    // Wait long enough for a full list search plus removal to give a stray result.
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/ple_pkg.sv
rtl/ple_ram.sv
rtl/ple_ctrl.sv
rtl/ple_dp.sv
rtl/positional_list_engine.sv
tb/tb_top.sv
